/* sv/pmq_pkg.sv */
// shared constants and codes for the priority message queue
`default_nettype none

package pmq_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int WIDTH_DEF   = 32;
    localparam int PRIO_W      = 8;
    localparam int CNT_W       = 5;
    localparam int STAT_W      = 2;
    localparam int CAP_RESET   = 16;

    localparam logic CMD_PUT = 1'b0;
    localparam logic CMD_GET = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

endpackage

`default_nettype wire

/* sv/pmq_ram.sv */
// single write, single registered read port memory for queue entries
`default_nettype none

module pmq_ram
    import pmq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int DW    = WIDTH_DEF + PRIO_W,
    localparam int IW   = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [IW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [IW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* sv/priority_message_queue_top.sv */
// priority ordered ring buffer message queue with an insertion walk sequencer
// a put walks back from the tail: stored entries of lower priority move one slot,
//   one per cycle, then the new entry is written; a put into empty writes at once
// a new word is taken only in idle, once the result is registered in the output;
//   an output stall holds the result and keeps the queue in S_OUT
// sync active-low reset empties the queue, capacity 16, store kept; cfg write empties too
`default_nettype none

module priority_message_queue_top
    import pmq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int WIDTH = WIDTH_DEF,
    localparam int IN_W  = ((WIDTH + PRIO_W + 7) / 8) * 8,
    localparam int OUT_W = ((WIDTH + PRIO_W + 2 * CNT_W + 7) / 8) * 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // cfg write: capacity
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [CNT_W-1:0]  i_cfg_data,
    // slave side
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [IN_W-1:0]   i_s_tdata,   // message_in, priority_in
    input  wire logic              i_s_tuser,   // command
    // master side
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [OUT_W-1:0]       o_m_tdata,   // message_out, priority_out, fill_count, free_space
    output logic [STAT_W-1:0]      o_m_tuser    // status
);

    localparam int IW = $clog2(DEPTH);
    localparam int XW = ((IW > CNT_W) ? IW : CNT_W) + 1;
    localparam int DW = WIDTH + PRIO_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_PLACE,
        S_GET,
        S_OUT
    } t_state;

    function automatic logic [IW-1:0] step_fwd(input logic [IW-1:0] i,
                                               input logic [CNT_W-1:0] cap);
        logic [XW-1:0] t;
        t = XW'(i) + XW'(1);
        return (t == XW'(cap)) ? '0 : IW'(t);
    endfunction

    function automatic logic [IW-1:0] step_back(input logic [IW-1:0] i,
                                                input logic [CNT_W-1:0] cap);
        logic [XW-1:0] t;
        t = XW'(cap) - XW'(1);
        return (i == '0) ? IW'(t) : i - IW'(1);
    endfunction

    t_state              r_state,     n_state;
    logic [CNT_W-1:0]    r_capacity,  n_capacity;
    logic [IW-1:0]       r_head,      n_head;
    logic [IW-1:0]       r_tail,      n_tail;
    logic [CNT_W-1:0]    r_held,      n_held;
    logic [IW-1:0]       r_pos,       n_pos;
    logic [CNT_W-1:0]    r_left,      n_left;
    logic [WIDTH-1:0]    r_msg,       n_msg;
    logic [PRIO_W-1:0]   r_prio,      n_prio;
    logic [STAT_W-1:0]   r_res_stat,  n_res_stat;
    logic [WIDTH-1:0]    r_res_msg,   n_res_msg;
    logic [PRIO_W-1:0]   r_res_prio,  n_res_prio;
    logic                r_out_valid, n_out_valid;
    logic [STAT_W-1:0]   r_out_stat,  n_out_stat;
    logic [WIDTH-1:0]    r_out_msg,   n_out_msg;
    logic [PRIO_W-1:0]   r_out_prio,  n_out_prio;
    logic [CNT_W-1:0]    r_out_fill,  n_out_fill;
    logic [CNT_W-1:0]    r_out_free,  n_out_free;

    logic [CNT_W-1:0]    w_cap;
    logic                w_we;
    logic [IW-1:0]       w_waddr;
    logic [DW-1:0]       w_wdata;
    logic [IW-1:0]       w_raddr;
    logic [DW-1:0]       w_rdata;
    logic [IW-1:0]       w_prev;
    logic [CNT_W-1:0]    w_left_dec;

    pmq_ram #(
        .DEPTH (DEPTH),
        .DW    (DW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        if (r_capacity == '0) begin
            w_cap = CNT_W'(1);
        end else if (int'(r_capacity) > DEPTH) begin
            w_cap = CNT_W'(DEPTH);
        end else begin
            w_cap = r_capacity;
        end
    end

    assign w_prev     = step_back(r_pos, w_cap);
    assign w_left_dec = r_left - CNT_W'(1);

    always_comb begin
        n_state     = r_state;
        n_capacity  = r_capacity;
        n_head      = r_head;
        n_tail      = r_tail;
        n_held      = r_held;
        n_pos       = r_pos;
        n_left      = r_left;
        n_msg       = r_msg;
        n_prio      = r_prio;
        n_res_stat  = r_res_stat;
        n_res_msg   = r_res_msg;
        n_res_prio  = r_res_prio;
        n_out_valid = r_out_valid;
        n_out_stat  = r_out_stat;
        n_out_msg   = r_out_msg;
        n_out_prio  = r_out_prio;
        n_out_fill  = r_out_fill;
        n_out_free  = r_out_free;
        w_we        = 1'b0;
        w_waddr     = r_pos;
        w_wdata     = {r_prio, r_msg};
        w_raddr     = step_back(w_prev, w_cap);

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_msg      = i_s_tdata[WIDTH-1:0];
                    n_prio     = i_s_tdata[WIDTH+PRIO_W-1:WIDTH];
                    n_res_stat = STAT_OK;
                    n_res_msg  = '0;
                    n_res_prio = '0;
                    if (i_s_tuser == CMD_PUT) begin
                        if (r_held >= w_cap) begin
                            n_res_stat = STAT_FULL;
                            n_state    = S_OUT;
                        end else if (r_held == '0) begin
                            w_we    = 1'b1;
                            w_waddr = r_tail;
                            w_wdata = i_s_tdata[DW-1:0];
                            n_tail  = step_fwd(r_tail, w_cap);
                            n_held  = r_held + CNT_W'(1);
                            n_state = S_OUT;
                        end else begin
                            n_pos   = r_tail;
                            n_left  = r_held;
                            w_raddr = step_back(r_tail, w_cap);
                            n_state = S_WALK;
                        end
                    end else begin
                        if (r_held == '0) begin
                            n_res_stat = STAT_EMPTY;
                            n_state    = S_OUT;
                        end else begin
                            w_raddr = r_head;
                            n_state = S_GET;
                        end
                    end
                end
            end
            S_WALK: begin
                w_we = 1'b1;
                if (r_prio <= w_rdata[DW-1:WIDTH]) begin
                    n_tail  = step_fwd(r_tail, w_cap);
                    n_held  = r_held + CNT_W'(1);
                    n_state = S_OUT;
                end else begin
                    w_wdata = w_rdata;
                    n_pos   = w_prev;
                    n_left  = w_left_dec;
                    if (w_left_dec == '0) begin
                        n_state = S_PLACE;
                    end
                end
            end
            S_PLACE: begin
                w_we    = 1'b1;
                n_tail  = step_fwd(r_tail, w_cap);
                n_held  = r_held + CNT_W'(1);
                n_state = S_OUT;
            end
            S_GET: begin
                n_res_msg  = w_rdata[WIDTH-1:0];
                n_res_prio = w_rdata[DW-1:WIDTH];
                n_head     = step_fwd(r_head, w_cap);
                n_held     = r_held - CNT_W'(1);
                n_state    = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_stat  = r_res_stat;
                    n_out_msg   = r_res_msg;
                    n_out_prio  = r_res_prio;
                    n_out_fill  = r_held;
                    n_out_free  = w_cap - r_held;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_valid) begin
            n_capacity = i_cfg_data;
            n_head     = '0;
            n_tail     = '0;
            n_held     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_capacity  <= CNT_W'(CAP_RESET);
            r_head      <= '0;
            r_tail      <= '0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_capacity  <= n_capacity;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_held      <= n_held;
            r_out_valid <= n_out_valid;
        end
        r_pos      <= n_pos;
        r_left     <= n_left;
        r_msg      <= n_msg;
        r_prio     <= n_prio;
        r_res_stat <= n_res_stat;
        r_res_msg  <= n_res_msg;
        r_res_prio <= n_res_prio;
        r_out_stat <= n_out_stat;
        r_out_msg  <= n_out_msg;
        r_out_prio <= n_out_prio;
        r_out_fill <= n_out_fill;
        r_out_free <= n_out_free;
    end

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tuser   = r_out_stat;
    assign o_m_tdata   = OUT_W'({r_out_free, r_out_fill, r_out_prio, r_out_msg});

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// testbench for the priority message queue: directed table, then random puts and gets
module tb_top
    import pmq_pkg::*;
();

    localparam int IN_W          = ((WIDTH_DEF + PRIO_W + 7) / 8) * 8;
    localparam int OUT_W         = ((WIDTH_DEF + PRIO_W + 2 * CNT_W + 7) / 8) * 8;
    localparam int PRIO_LSB      = WIDTH_DEF;
    localparam int FILL_LSB      = WIDTH_DEF + PRIO_W;
    localparam int SPACE_LSB     = FILL_LSB + CNT_W;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 24;
    localparam int PHASE_WORDS   = 155;
    localparam int N_PHASES      = 12;
    localparam int N_ROWS        = 26;

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [WIDTH_DEF-1:0] msg;
        logic [PRIO_W-1:0]    prio;
        logic [CNT_W-1:0]     fill;
        logic [CNT_W-1:0]     space;
    } t_pmq_result;

    typedef enum logic {ROW_WORD, ROW_CAP} t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic                 cmd;
        logic [WIDTH_DEF-1:0] msg;
        logic [PRIO_W-1:0]    prio;
        logic [CNT_W-1:0]     cap;
        logic                 known;
        t_pmq_result          res;
    } t_dir_row;

    localparam t_pmq_result NO_RES = '0;

    localparam t_dir_row DIRECTED_ROWS [N_ROWS] = '{
        '{ROW_WORD, CMD_GET, 32'h0000_0000, 8'h00, 5'd0, 1'b1,
          '{STAT_EMPTY, 32'h0, 8'h00, 5'd0, 5'd16}},
        '{ROW_WORD, CMD_PUT, 32'h0000_0000, 8'h00, 5'd0, 1'b1,
          '{STAT_OK, 32'h0, 8'h00, 5'd1, 5'd15}},
        '{ROW_WORD, CMD_PUT, 32'hFFFF_FFFF, 8'hFF, 5'd0, 1'b1,
          '{STAT_OK, 32'h0, 8'h00, 5'd2, 5'd14}},
        '{ROW_WORD, CMD_PUT, 32'h1234_5678, 8'h80, 5'd0, 1'b0, NO_RES},
        '{ROW_WORD, CMD_PUT, 32'hA5A5_A5A5, 8'h80, 5'd0, 1'b0, NO_RES},
        '{ROW_WORD, CMD_PUT, 32'h5A5A_5A5A, 8'h01, 5'd0, 1'b0, NO_RES},
        '{ROW_WORD, CMD_PUT, 32'h0000_0001, 8'h80, 5'd0, 1'b0, NO_RES},
        '{ROW_WORD, CMD_GET, 32'h0000_0000, 8'h00, 5'd0, 1'b1,
          '{STAT_OK, 32'hFFFF_FFFF, 8'hFF, 5'd5, 5'd11}},
        '{ROW_WORD, CMD_GET, 32'h0000_0000, 8'h00, 5'd0, 1'b0, NO_RES},
        '{ROW_WORD, CMD_GET, 32'h0000_0000, 8'h00, 5'd0, 1'b0, NO_RES},
        '{ROW_WORD, CMD_GET, 32'h0000_0000, 8'h00, 5'd0, 1'b0, NO_RES},
        '{ROW_WORD, CMD_GET, 32'h0000_0000, 8'h00, 5'd0, 1'b0, NO_RES},
        '{ROW_WORD, CMD_GET, 32'h0000_0000, 8'h00, 5'd0, 1'b0, NO_RES},
        '{ROW_WORD, CMD_GET, 32'h0000_0000, 8'h00, 5'd0, 1'b1,
          '{STAT_EMPTY, 32'h0, 8'h00, 5'd0, 5'd16}},
        '{ROW_CAP,  CMD_PUT, 32'h0000_0000, 8'h00, 5'd1, 1'b0, NO_RES},
        '{ROW_WORD, CMD_PUT, 32'hDEAD_BEEF, 8'h07, 5'd0, 1'b1,
          '{STAT_OK, 32'h0, 8'h00, 5'd1, 5'd0}},
        '{ROW_WORD, CMD_PUT, 32'h0000_0001, 8'hFF, 5'd0, 1'b1,
          '{STAT_FULL, 32'h0, 8'h00, 5'd1, 5'd0}},
        '{ROW_WORD, CMD_GET, 32'h0000_0000, 8'h00, 5'd0, 1'b1,
          '{STAT_OK, 32'hDEAD_BEEF, 8'h07, 5'd0, 5'd1}},
        '{ROW_CAP,  CMD_PUT, 32'h0000_0000, 8'h00, 5'd0, 1'b0, NO_RES},
        '{ROW_WORD, CMD_PUT, 32'h0000_0055, 8'h03, 5'd0, 1'b1,
          '{STAT_OK, 32'h0, 8'h00, 5'd1, 5'd0}},
        '{ROW_WORD, CMD_PUT, 32'h0000_0066, 8'h09, 5'd0, 1'b1,
          '{STAT_FULL, 32'h0, 8'h00, 5'd1, 5'd0}},
        '{ROW_CAP,  CMD_PUT, 32'h0000_0000, 8'h00, 5'd31, 1'b0, NO_RES},
        '{ROW_WORD, CMD_PUT, 32'h0000_AAAA, 8'h10, 5'd0, 1'b0, NO_RES},
        '{ROW_WORD, CMD_PUT, 32'h0000_5555, 8'h20, 5'd0, 1'b0, NO_RES},
        '{ROW_WORD, CMD_GET, 32'h0000_0000, 8'h00, 5'd0, 1'b0, NO_RES},
        '{ROW_WORD, CMD_GET, 32'h0000_0000, 8'h00, 5'd0, 1'b0, NO_RES}
    };

    localparam logic [CNT_W-1:0] PHASE_CAPS [N_PHASES] = '{
        5'd16, 5'd2, 5'd1, 5'd5, 5'd0, 5'd31, 5'd17, 5'd3, 5'd16, 5'd8, 5'd4, 5'd12
    };

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [CNT_W-1:0]  cfg_data  = '0;
    logic              cfg_ready;
    logic              s_tvalid  = 1'b0;
    logic [IN_W-1:0]   s_tdata   = '0;    // message_in, priority_in
    logic              s_tuser   = 1'b0;  // command
    logic              s_tready;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [OUT_W-1:0]  m_tdata;           // message_out, priority_out, fill_count, free_space
    logic [STAT_W-1:0] m_tuser;           // status

    // predictor state
    logic [WIDTH_DEF-1:0] slot_msg  [DEPTH_DEF];
    logic [PRIO_W-1:0]    slot_prio [DEPTH_DEF];
    int                   q_head;
    int                   q_tail;
    int                   q_held;
    logic [CNT_W-1:0]     q_cap_reg;

    t_pmq_result pending_results [$];
    int          error_count = 0;
    int          idle_cycles = 0;
    int          burst_left  = 0;
    int          rx_cycle    = 0;

    priority_message_queue_top DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser)
    );

    always #5 clk = ~clk;

    function automatic int usable_slots();
        int c;
        c = int'(q_cap_reg);
        if (c == 0)
            c = 1;
        if (c > DEPTH_DEF)
            c = DEPTH_DEF;
        return c;
    endfunction

    function automatic t_pmq_result predict_access(input logic cmd,
                                                   input logic [WIDTH_DEF-1:0] msg,
                                                   input logic [PRIO_W-1:0] prio);
        t_pmq_result r;
        int slots;
        int pos;
        int prev;
        int left;
        r = NO_RES;
        slots = usable_slots();
        if (cmd == CMD_PUT) begin
            if (q_held >= slots) begin
                r.status = STAT_FULL;
            end else begin
                // walk from the tail, lower priorities slide one slot back
                pos = q_tail;
                left = q_held;
                while (left > 0) begin
                    prev = (pos + slots - 1) % slots;
                    if (prio <= slot_prio[prev])
                        break;
                    slot_msg[pos]  = slot_msg[prev];
                    slot_prio[pos] = slot_prio[prev];
                    pos = prev;
                    left--;
                end
                slot_msg[pos]  = msg;
                slot_prio[pos] = prio;
                q_tail = (q_tail + 1) % slots;
                q_held++;
            end
        end else begin
            if (q_held == 0) begin
                r.status = STAT_EMPTY;
            end else begin
                r.msg  = slot_msg[q_head];
                r.prio = slot_prio[q_head];
                q_head = (q_head + 1) % slots;
                q_held--;
            end
        end
        r.fill  = CNT_W'(q_held);
        r.space = CNT_W'(slots - q_held);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [WIDTH_DEF-1:0] want,
                                        input logic [WIDTH_DEF-1:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk) begin : result_check
        t_pmq_result got;
        t_pmq_result want;
        if (rst_n && m_tvalid && m_tready) begin
            got.status = m_tuser;
            got.msg    = m_tdata[WIDTH_DEF-1:0];
            got.prio   = m_tdata[PRIO_LSB +: PRIO_W];
            got.fill   = m_tdata[FILL_LSB +: CNT_W];
            got.space  = m_tdata[SPACE_LSB +: CNT_W];
            if (pending_results.size() == 0) begin
                $display("%0t ns: unexpected word, status %0h message %0h priority %0h",
                         $time, got.status, got.msg, got.prio);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", WIDTH_DEF'(want.status), WIDTH_DEF'(got.status));
                check_field("message_out", want.msg, got.msg);
                check_field("priority_out", WIDTH_DEF'(want.prio), WIDTH_DEF'(got.prio));
                check_field("fill_count", WIDTH_DEF'(want.fill), WIDTH_DEF'(got.fill));
                check_field("free_space", WIDTH_DEF'(want.space), WIDTH_DEF'(got.space));
            end
        end
    end

    // receiver: long ready stretches, coin-flip stalls, heavy stalls
    always @(posedge clk) begin
        rx_cycle <= rx_cycle + 1;
        case ((rx_cycle / 300) % 3)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[priority_message_queue_top] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_word(input logic cmd, input logic [WIDTH_DEF-1:0] msg,
                             input logic [PRIO_W-1:0] prio, input logic known,
                             input t_pmq_result known_res);
        t_pmq_result r;
        int gap;
        if (burst_left == 0)
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= IN_W'({prio, msg});
        do @(posedge clk); while (!s_tready);
        r = predict_access(cmd, msg, prio);
        pending_results.push_back(known ? known_res : r);
        burst_left--;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 4);
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        if (burst_left != 0) begin
            s_tvalid <= 1'b0;
            burst_left = 0;
        end
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CNT_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        q_cap_reg = value;
        q_head = 0;
        q_tail = 0;
        q_held = 0;
    endtask

    task automatic random_phase(input int n_words);
        int put_pct;
        logic cmd;
        logic [PRIO_W-1:0] prio;
        put_pct = 50;
        for (int i = 0; i < n_words; i++) begin
            // swing between filling and emptying
            if (i % 24 == 0) begin
                case ($urandom_range(0, 2))
                    0:       put_pct = 20;
                    1:       put_pct = 50;
                    default: put_pct = 80;
                endcase
            end
            cmd = ($urandom_range(1, 100) <= put_pct) ? CMD_PUT : CMD_GET;
            case ($urandom_range(0, 3))
                0, 1:    prio = PRIO_W'($urandom_range(0, 3));
                2:       prio = PRIO_W'($urandom);
                default: prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            endcase
            send_word(cmd, $urandom, prio, 1'b0, NO_RES);
        end
    endtask

    initial begin
        q_head = 0;
        q_tail = 0;
        q_held = 0;
        q_cap_reg = CNT_W'(CAP_RESET);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < N_ROWS; i++) begin
            if (DIRECTED_ROWS[i].kind == ROW_CAP)
                write_capacity(DIRECTED_ROWS[i].cap);
            else
                send_word(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].msg, DIRECTED_ROWS[i].prio,
                          DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].res);
        end
        for (int p = 0; p < N_PHASES; p++) begin
            write_capacity(PHASE_CAPS[p]);
            random_phase(PHASE_WORDS);
        end
        drain_results();
        if (error_count == 0)
            $display("[priority_message_queue_top] OK");
        else
            $display("[priority_message_queue_top] ERROR");
        $finish;
    end

endmodule

/* priority_message_queue_top.f */
sv/pmq_pkg.sv
sv/pmq_ram.sv
sv/priority_message_queue_top.sv
verif/tb_top.sv
